/* design/wrm_pkg.sv */
`default_nettype none

package wrm_pkg;

    // default geometry
    localparam int unsigned SAMPLE_BITS_DEF = 16;
    localparam int unsigned WINDOW_BITS_DEF = 16;

    // register defaults after reset
    localparam int unsigned WINDOW_RESET = 1024;
    localparam logic        STEREO_RESET = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_START,
        S_CALC,
        S_HOLD
    } t_state;

    // per-lane control from the sequencer
    typedef struct packed {
        logic acc;    // add the held sample to the sums
        logic clr;    // drop the partial window first
        logic start;  // close the window: launch divide and root
    } t_lane_ctrl;

endpackage

`default_nettype wire

/* design/wrm_div.sv */
`default_nettype none

module wrm_div import wrm_pkg::*; #(
    parameter int unsigned NUM_BITS = 32,
    parameter int unsigned DEN_BITS = WINDOW_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic      [NUM_BITS-1:0] o_quot,
    output logic                     o_done
);

    localparam int unsigned CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DEN_BITS:0]   w_shift;
    logic [DEN_BITS:0]   w_diff;
    logic                w_ge;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_BITS-1]};
        w_ge    = (w_shift >= {1'b0, r_den});
        w_diff  = w_shift - {1'b0, r_den};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_BITS-1:0] : w_shift[DEN_BITS-1:0];
            r_quo <= {r_quo[NUM_BITS-2:0], w_ge};
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* design/wrm_sqrt.sv */
`default_nettype none

module wrm_sqrt import wrm_pkg::*; #(
    parameter int unsigned RAD_BITS = 46
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [RAD_BITS-1:0]   i_rad,
    output logic      [RAD_BITS/2-1:0] o_root,
    output logic                       o_done
);

    localparam int unsigned ROOT_BITS = RAD_BITS / 2;
    localparam int unsigned CNT_BITS  = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

    logic [RAD_BITS-1:0]  r_x;
    logic [ROOT_BITS:0]   r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [ROOT_BITS+2:0] w_remt;
    logic [ROOT_BITS+2:0] w_trial;
    logic [ROOT_BITS+2:0] w_diff;
    logic                 w_ge;

    // one digit: bring down two radicand bits, try root*4+1
    always_comb begin
        w_remt  = {r_rem, r_x[RAD_BITS-1:RAD_BITS-2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = (w_remt >= w_trial);
        w_diff  = w_remt - w_trial;
    end

    // digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(ROOT_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // radicand shift, partial remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_BITS-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[ROOT_BITS:0] : w_remt[ROOT_BITS:0];
            r_root <= {r_root[ROOT_BITS-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* design/wrm_lane.sv */
`default_nettype none

module wrm_lane import wrm_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_lane_ctrl                    i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic        [WINDOW_BITS-1:0] i_window,
    output logic             [SAMPLE_BITS-2:0] o_rms,
    output logic             [SAMPLE_BITS-1:0] o_average,
    output logic                               o_done
);

    localparam int unsigned MAG_BITS = SAMPLE_BITS - 1;
    localparam int unsigned ABS_BITS = MAG_BITS + WINDOW_BITS;
    localparam int unsigned SQS_BITS = 2 * MAG_BITS + WINDOW_BITS;
    localparam int unsigned RAD_BITS = SQS_BITS + (SQS_BITS % 2);
    localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

    logic [ABS_BITS-1:0]   r_abs_sum;
    logic [SQS_BITS-1:0]   r_sq_sum;

    logic [SAMPLE_BITS-1:0] w_neg;
    logic [MAG_BITS-1:0]    w_mag;
    logic [2*MAG_BITS-1:0]  w_sq;
    logic [ABS_BITS-1:0]    w_abs_base;
    logic [SQS_BITS-1:0]    w_sq_base;

    logic [ABS_BITS:0]      w_avg_quot;
    logic [SQS_BITS-1:0]    w_ms_quot;
    logic                   w_ms_done;
    logic [RAD_BITS/2-1:0]  w_root;
    logic                   w_avg_done;

    // magnitude, saturated at the largest positive sample, and its square
    always_comb begin
        w_neg = -i_sample;
        if (!i_sample[SAMPLE_BITS-1]) begin
            w_mag = i_sample[MAG_BITS-1:0];
        end else if (w_neg[SAMPLE_BITS-1]) begin
            w_mag = MAG_MAX;
        end else begin
            w_mag = w_neg[MAG_BITS-1:0];
        end
        w_sq       = w_mag * w_mag;
        w_abs_base = i_ctrl.clr ? '0 : r_abs_sum;
        w_sq_base  = i_ctrl.clr ? '0 : r_sq_sum;
    end

    // running sums: drop on clear or window close, add on accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_sum <= '0;
            r_sq_sum  <= '0;
        end else if (i_ctrl.start) begin
            r_abs_sum <= '0;
            r_sq_sum  <= '0;
        end else if (i_ctrl.acc) begin
            r_abs_sum <= w_abs_base + ABS_BITS'(w_mag);
            r_sq_sum  <= w_sq_base + SQS_BITS'(w_sq);
        end else if (i_ctrl.clr) begin
            r_abs_sum <= '0;
            r_sq_sum  <= '0;
        end
    end

    // twice the magnitude sum over the window length
    wrm_div #(
        .NUM_BITS (ABS_BITS + 1),
        .DEN_BITS (WINDOW_BITS)
    ) u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.start),
        .i_num   ({r_abs_sum, 1'b0}),
        .i_den   (i_window),
        .o_quot  (w_avg_quot),
        .o_done  (w_avg_done)
    );

    // mean square
    wrm_div #(
        .NUM_BITS (SQS_BITS),
        .DEN_BITS (WINDOW_BITS)
    ) u_ms_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.start),
        .i_num   (r_sq_sum),
        .i_den   (i_window),
        .o_quot  (w_ms_quot),
        .o_done  (w_ms_done)
    );

    // root of the mean square, launched when the longer divide ends
    wrm_sqrt #(
        .RAD_BITS (RAD_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ms_done),
        .i_rad   (RAD_BITS'(w_ms_quot)),
        .o_root  (w_root),
        .o_done  (o_done)
    );

    assign o_rms     = w_root[SAMPLE_BITS-2:0];
    assign o_average = w_avg_quot[SAMPLE_BITS-1:0];

`ifndef SYNTHESIS
    // the average divide is shorter and must finish before the root does
    a_avg_before_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_avg_done |-> !o_done)
        else $error("lane: average divide ended with the root");

    // the mean-square divide is never done at once after a window closes
    a_ms_done_not_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |=> !w_ms_done)
        else $error("lane: mean-square divide ended straight after launch");

    // a sample is never added in the cycle that closes the window
    a_acc_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.acc && i_ctrl.start))
        else $error("lane: accumulate and window close together");
`endif

endmodule

`default_nettype wire

/* design/windowed_rms_and_mean_level_unit.sv */
// Stereo level meter: per-channel RMS and mean absolute level over a window.
// Input channel (i_in_valid / o_in_stall) carries one word per stereo sample
// pair plus a clear flag that drops the partial window before the pair is
// added. The output channel (o_out_valid / i_out_stall) carries one word per
// completed window: floor root of the floor mean square and the floor of
// twice the mean magnitude for each side; right results read zero in mono.
// A word that does not close a window is taken in the idle state and added
// to the sums in the accumulate state; only then is the next word taken.
// A word that closes the window then passes the start and compute states:
// a bit-serial divider of SQ steps, SQ = 2*(SAMPLE_BITS-1)+WINDOW_BITS,
// followed by a two-bit-per-step root in each lane, and then the hold state;
// both lanes run side by side. Input is stalled meanwhile.
// A finished result waits in the output register while the next sample
// words are taken; only a second finished result waits for the receiver.
// Configuration writes go through i_cfg_we / i_cfg_index / i_cfg_wdata and
// belong to idle periods. Reset clears the sums and position, drops any
// pending result and restores a 1024-sample stereo window.
`default_nettype none

module windowed_rms_and_mean_level_unit import wrm_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  wire logic [WINDOW_BITS-1:0]        i_cfg_wdata,
    // sample words
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  wire logic                          i_clear,
    // result words
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic             [SAMPLE_BITS-2:0] o_rms_left,
    output logic             [SAMPLE_BITS-2:0] o_rms_right,
    output logic             [SAMPLE_BITS-1:0] o_average_left,
    output logic             [SAMPLE_BITS-1:0] o_average_right
);

    t_state                  r_state;
    t_state                  n_state;

    logic [WINDOW_BITS-1:0]  r_window;
    logic                    r_stereo;
    logic [WINDOW_BITS-1:0]  r_pos;

    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                          r_clear;

    logic                    r_out_valid;
    logic [SAMPLE_BITS-2:0]  r_rms_left;
    logic [SAMPLE_BITS-2:0]  r_rms_right;
    logic [SAMPLE_BITS-1:0]  r_avg_left;
    logic [SAMPLE_BITS-1:0]  r_avg_right;

    logic                    w_accept;
    logic [WINDOW_BITS-1:0]  w_n;
    logic [WINDOW_BITS-1:0]  w_pos_next;
    logic                    w_close;
    logic                    w_slot_free;
    logic                    w_load;
    t_lane_ctrl              w_ctrl_l;
    t_lane_ctrl              w_ctrl_r;

    logic [SAMPLE_BITS-2:0]  w_rms_l;
    logic [SAMPLE_BITS-2:0]  w_rms_r;
    logic [SAMPLE_BITS-1:0]  w_avg_l;
    logic [SAMPLE_BITS-1:0]  w_avg_r;
    logic                    w_done_l;
    logic                    w_done_r;

    // window length, zero read as one; position after this word
    always_comb begin
        w_n        = (r_window == '0) ? WINDOW_BITS'(1) : r_window;
        w_pos_next = r_clear ? WINDOW_BITS'(1) : r_pos + 1'b1;
        w_close    = (w_pos_next == '0) || (w_pos_next >= w_n);
        w_accept   = i_in_valid && !o_in_stall;
        w_slot_free = !r_out_valid || !i_out_stall;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_BITS'(WINDOW_RESET);
            r_stereo <= STEREO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW: r_window <= i_cfg_wdata;
                CFG_STEREO: r_stereo <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_ACC;
            S_ACC:   n_state = w_close ? S_START : S_IDLE;
            S_START: n_state = S_CALC;
            S_CALC:  if (w_done_l) n_state = S_HOLD;
            S_HOLD:  if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_load     = 1'b0;
        w_ctrl_l   = '0;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_ACC: begin
                w_ctrl_l.acc = 1'b1;
                w_ctrl_l.clr = r_clear;
            end
            S_START: w_ctrl_l.start = 1'b1;
            S_CALC:  ;
            S_HOLD:  w_load = w_slot_free;
            default: ;
        endcase
        w_ctrl_r     = w_ctrl_l;
        w_ctrl_r.acc = w_ctrl_l.acc && r_stereo;
    end

    // state and window position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_pos <= w_close ? '0 : w_pos_next;
            end
        end
    end

    // hold the accepted word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
            r_clear <= i_clear;
        end
    end

    wrm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_lane_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl_l),
        .i_sample  (r_left),
        .i_window  (w_n),
        .o_rms     (w_rms_l),
        .o_average (w_avg_l),
        .o_done    (w_done_l)
    );

    wrm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_lane_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl_r),
        .i_sample  (r_right),
        .i_window  (w_n),
        .o_rms     (w_rms_r),
        .o_average (w_avg_r),
        .o_done    (w_done_r)
    );

    // merge lanes into the output register; zero the right side in mono
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rms_left  <= w_rms_l;
            r_avg_left  <= w_avg_l;
            r_rms_right <= r_stereo ? w_rms_r : '0;
            r_avg_right <= r_stereo ? w_avg_r : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rms_left      = r_rms_left;
    assign o_rms_right     = r_rms_right;
    assign o_average_left  = r_avg_left;
    assign o_average_right = r_avg_right;

`ifndef SYNTHESIS
    // both lanes run in lock step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_l == w_done_r)
        else $error("lanes finished out of step");

    // a taken word is accumulated in the next cycle
    a_accept_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ACC))
        else $error("accepted word not accumulated");

    // a new result appears only after a window was computed
    a_result_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_HOLD))
        else $error("result raised outside the hold state");

    // lane results finish only while the sequencer waits for them
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_l |-> (r_state == S_CALC))
        else $error("lane finished outside the compute state");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_windowed_rms_and_mean_level_unit.sv */
`timescale 1ns / 100ps

module tb_windowed_rms_and_mean_level_unit;
    import wrm_pkg::*;

    localparam int unsigned SB = SAMPLE_BITS_DEF;
    localparam int unsigned WB = WINDOW_BITS_DEF;
    localparam longint unsigned MAG_MAX = (64'd1 << (SB - 1)) - 1;
    // idle wait after the last level word; leave margin
    localparam int SETTLE_CYCLES = 160;
    localparam int LONG_HOLD_CYCLES = 1000;
    localparam int RANDOM_WORDS = 2000;

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 clr;
    } t_sample_word;

    typedef struct packed {
        logic [SB-2:0] rms_l;
        logic [SB-2:0] rms_r;
        logic [SB-1:0] avg_l;
        logic [SB-1:0] avg_r;
    } t_level_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_WINDOW;
    logic [WB-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [SB-1:0] i_left_sample = '0;
    logic signed [SB-1:0] i_right_sample = '0;
    logic i_clear = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [SB-2:0] o_rms_left;
    logic [SB-2:0] o_rms_right;
    logic [SB-1:0] o_average_left;
    logic [SB-1:0] o_average_right;

    windowed_rms_and_mean_level_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_clear        (i_clear),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rms_left     (o_rms_left),
        .o_rms_right    (o_rms_right),
        .o_average_left (o_average_left),
        .o_average_right(o_average_right)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // meter state mirrored from the block, plus its register copies
    logic [WB-1:0] win_len = WB'(WINDOW_RESET);
    logic stereo_on = STEREO_RESET;
    logic [WB-1:0] win_pos = '0;
    longint unsigned abs_sum_l = 0;
    longint unsigned abs_sum_r = 0;
    longint unsigned sq_sum_l = 0;
    longint unsigned sq_sum_r = 0;

    t_sample_word pending_words[$];
    t_level_word  expected_levels[$];

    int errors = 0;
    int src_max_gap = 0;
    int snk_max_stall = 0;
    int holds_asked = 0;

    function automatic longint unsigned magnitude_of(logic signed [SB-1:0] s);
        logic [SB:0] m;
        m = s[SB-1] ? -{s[SB-1], s} : {1'b0, s};
        // most negative value has no positive twin: saturate
        return (m > MAG_MAX) ? MAG_MAX : longint'(m);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic void clear_sums();
        win_pos = '0;
        abs_sum_l = 0;
        abs_sum_r = 0;
        sq_sum_l = 0;
        sq_sum_r = 0;
    endfunction

    // add one stereo pair to the window; report the levels if it closes
    task automatic take_sample(input t_sample_word w, output bit closed,
                               output t_level_word lv);
        longint unsigned ml;
        longint unsigned mr;
        longint unsigned n;
        if (w.clr) clear_sums();
        ml = magnitude_of(w.left);
        abs_sum_l += ml;
        sq_sum_l += ml * ml;
        if (stereo_on) begin
            mr = magnitude_of(w.right);
            abs_sum_r += mr;
            sq_sum_r += mr * mr;
        end
        win_pos = win_pos + 1'b1;
        // a zero length behaves as one; a shortened window closes at once
        n = (win_len == 0) ? 1 : longint'(win_len);
        closed = !(win_pos != 0 && win_pos < n);
        lv = '0;
        if (closed) begin
            lv.rms_l = (SB-1)'(floor_root(sq_sum_l / n));
            lv.avg_l = SB'((2 * abs_sum_l) / n);
            if (stereo_on) begin
                lv.rms_r = (SB-1)'(floor_root(sq_sum_r / n));
                lv.avg_r = SB'((2 * abs_sum_r) / n);
            end
            clear_sums();
        end
    endtask

    // sample word driver: present queued words with random gaps
    always @(posedge i_clk) begin : drive_samples
        t_sample_word w;
        t_level_word lv;
        bit closed;
        logic nxt_valid;
        int gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                w = {i_left_sample, i_right_sample, i_clear};
                take_sample(w, closed, lv);
                if (closed) expected_levels = {expected_levels, lv};
                gap_left = (src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    i_left_sample <= w.left;
                    i_right_sample <= w.right;
                    i_clear <= w.clr;
                    nxt_valid = 1'b1;
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // level word monitor: stall at random, hold off on request, compare
    always @(posedge i_clk) begin : watch_levels
        t_level_word want;
        int stall_left;
        int hold_left;
        int holds_served;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            holds_served = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_levels.size() == 0) begin
                    errors++;
                    $display("%0t: level word with none expected: rms %0d/%0d avg %0d/%0d",
                             $time, o_rms_left, o_rms_right, o_average_left,
                             o_average_right);
                end else begin
                    want = expected_levels.pop_front();
                    check_field("left rms", want.rms_l, o_rms_left);
                    check_field("right rms", want.rms_r, o_rms_right);
                    check_field("left average", want.avg_l, o_average_left);
                    check_field("right average", want.avg_r, o_average_right);
                end
                stall_left = (snk_max_stall == 0) ? 0 : $urandom_range(0, snk_max_stall);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left = LONG_HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_out_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    // wait until every word is taken and every level word is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_levels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [WB-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WINDOW) win_len = data;
        else stereo_on = data[0];
        @(negedge i_clk);
    endtask

    task automatic queue_word(input logic signed [SB-1:0] l,
                              input logic signed [SB-1:0] r, input logic c);
        t_sample_word w;
        w.left = l;
        w.right = r;
        w.clr = c;
        pending_words = {pending_words, w};
    endtask

    function automatic logic signed [SB-1:0] pick_sample();
        logic signed [SB-1:0] v;
        case ($urandom_range(0, 9))
            0: v = {1'b1, {(SB-1){1'b0}}};
            1: v = {1'b0, {(SB-1){1'b1}}};
            2: v = '0;
            3: v = '1;
            4, 5: begin
                v = SB'($urandom_range(0, 15));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = SB'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_random(input int count);
        repeat (count) queue_word(pick_sample(), pick_sample(), $urandom_range(0, 29) == 0);
    endtask

    initial begin : run_stimulus
        int sent;
        int cnt;
        logic [WB-1:0] win;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window stays open, then shorten it under the partial window
        src_max_gap = 3;
        snk_max_stall = 3;
        queue_random(3);
        wait_idle();
        write_reg(CFG_WINDOW, 2);
        queue_random(1);
        wait_idle();

        // one-sample windows at the sample extremes
        write_reg(CFG_WINDOW, 1);
        queue_word(16'sh8000, 16'sh7fff, 1'b0);
        queue_word(16'sh7fff, 16'sh8000, 1'b0);
        queue_word(16'sh0000, 16'shffff, 1'b0);
        queue_word(16'shffff, 16'sh0000, 1'b1);
        queue_word(16'sh0001, 16'sh0001, 1'b0);
        wait_idle();

        // zero length acts as one
        write_reg(CFG_WINDOW, 0);
        queue_random(2);
        wait_idle();

        // mono with upper data bits set, clear dropping a partial window
        write_reg(CFG_WINDOW, 3);
        write_reg(CFG_STEREO, 16'hfffe);
        queue_word(16'sh8000, 16'sh8000, 1'b0);
        queue_word(16'sh1234, 16'shedcb, 1'b0);
        queue_word(16'sh7fff, 16'sh7fff, 1'b1);
        queue_word(16'sh8001, 16'sh4000, 1'b0);
        queue_word(16'sh0100, 16'shff00, 1'b0);
        wait_idle();

        // stereo switched off, then on, half way through a window
        write_reg(CFG_STEREO, 16'h0001);
        write_reg(CFG_WINDOW, 4);
        queue_random(2);
        wait_idle();
        write_reg(CFG_STEREO, 16'h0000);
        queue_random(2);
        wait_idle();
        queue_random(2);
        wait_idle();
        write_reg(CFG_STEREO, 16'hffff);
        queue_random(2);
        wait_idle();

        // longest window, closed early by shortening it
        write_reg(CFG_WINDOW, 16'hffff);
        queue_random(3);
        wait_idle();
        write_reg(CFG_WINDOW, 2);
        queue_random(1);
        wait_idle();

        // hold the receiver off while words keep coming, so input backs up
        write_reg(CFG_WINDOW, 1);
        src_max_gap = 0;
        snk_max_stall = 0;
        holds_asked++;
        queue_random(40);
        wait_idle();

        // random phases; partial windows carry across register changes
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 19))
                14, 15, 16, 17: win = WB'($urandom_range(9, 64));
                18:             win = WB'($urandom_range(65, 400));
                19:             win = $urandom_range(0, 1) ? '0 : '1;
                default:        win = WB'($urandom_range(1, 8));
            endcase
            if ($urandom_range(0, 3) != 0) write_reg(CFG_WINDOW, win);
            if ($urandom_range(0, 1) != 0) write_reg(CFG_STEREO, WB'($urandom));
            src_max_gap = $urandom_range(0, 1) * 15;
            snk_max_stall = $urandom_range(0, 1) * 15;
            cnt = $urandom_range(10, 120);
            queue_random(cnt);
            sent += cnt;
            wait_idle();
        end

        if (errors == 0) begin
            $display("windowed_rms_and_mean_level_unit verification clean");
        end else begin
            $display("windowed_rms_and_mean_level_unit verification failed");
        end
        $finish;
    end

    // give up if the run stalls
    initial begin : watchdog
        #20_000_000;
        $display("windowed_rms_and_mean_level_unit verification failed");
        $finish;
    end

endmodule
